// ----- design/bop_pkg.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bop_pkg: shared types and constants for the camera pose pipeline
// Fixed-point constants, divider reciprocals, register codes and stage types.
// ---------------------------------------------------------------------------
package bop_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GIMBAL_MODE = 3'd0,
    REG_FPV_FWD     = 3'd1,
    REG_FPV_UP      = 3'd2,
    REG_GIM_FWD     = 3'd3,
    REG_GIM_UP      = 3'd4
  } cfg_reg_t;

  localparam logic [30:0]        Q_ONE        = 31'h4000_0000;
  localparam logic signed [16:0] FULL_TURN    = 17'sd23040;
  localparam logic signed [16:0] QUARTER_TURN = 17'sd5760;
  localparam logic [18:0]        RAD_PER_UNIT = 19'd292818;
  localparam logic signed [20:0] RAD_TO_UNIT  = 21'sd938734;

  localparam int NSTEP = 6;

  // Exact floor(p / d) for any 32-bit p: (p * M) >> K
  localparam int SIN_K [NSTEP] = '{40, 39, 39, 38, 37, 35};
  localparam int COS_K [NSTEP] = '{40, 39, 38, 37, 36, 33};
  localparam logic [32:0] SIN_M [NSTEP] = '{
    33'((64'd1 << 40) / 64'd156 + 64'd1), 33'((64'd1 << 39) / 64'd110 + 64'd1),
    33'((64'd1 << 39) / 64'd72 + 64'd1),  33'((64'd1 << 38) / 64'd42 + 64'd1),
    33'((64'd1 << 37) / 64'd20 + 64'd1),  33'((64'd1 << 35) / 64'd6 + 64'd1)};
  localparam logic [32:0] COS_M [NSTEP] = '{
    33'((64'd1 << 40) / 64'd132 + 64'd1), 33'((64'd1 << 39) / 64'd90 + 64'd1),
    33'((64'd1 << 38) / 64'd56 + 64'd1),  33'((64'd1 << 37) / 64'd30 + 64'd1),
    33'((64'd1 << 36) / 64'd12 + 64'd1),  33'((64'd1 << 33) / 64'd2 + 64'd1)};

  typedef struct packed {
    logic               lose;
    logic signed [31:0] vx;
    logic signed [31:0] vy;
    logic signed [31:0] vz;
    logic signed [15:0] hd;
    logic signed [15:0] pt;
    logic signed [15:0] rl;
    logic signed [15:0] gh;
    logic signed [15:0] gp;
  } carry_t;

  typedef struct packed {
    logic [1:0]  q;
    logic [30:0] x;
    logic [31:0] x2;
    logic [30:0] ts;
    logic [30:0] tc;
    logic [31:0] ps;
    logic [31:0] pc;
  } lane_t;

  // Round a Q30 product back to Q30 (add half, floor)
  function automatic logic signed [33:0] rnd30(input logic signed [63:0] v);
    logic signed [63:0] w;
    w = (v + 64'sd536870912) >>> 30;
    return w[33:0];
  endfunction

endpackage

// ----- design/bop_if.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bop_if: pose input and camera output channels
// Valid/ready channels carrying the vehicle pose and the camera pose.
// ---------------------------------------------------------------------------
interface bop_in_if;
  logic               valid;
  logic               ready;
  logic               losing_control;
  logic signed [31:0] vehicle_x;
  logic signed [31:0] vehicle_y;
  logic signed [31:0] vehicle_z;
  logic signed [15:0] vehicle_heading;
  logic signed [15:0] vehicle_pitch;
  logic signed [15:0] vehicle_roll;
  logic signed [15:0] gimbal_pan;
  logic signed [15:0] gimbal_tilt;

  modport source (output valid, losing_control, vehicle_x, vehicle_y, vehicle_z,
                  vehicle_heading, vehicle_pitch, vehicle_roll, gimbal_pan,
                  gimbal_tilt, input ready);
  modport sink (input valid, losing_control, vehicle_x, vehicle_y, vehicle_z,
                vehicle_heading, vehicle_pitch, vehicle_roll, gimbal_pan,
                gimbal_tilt, output ready);
endinterface

interface bop_out_if;
  logic               valid;
  logic               ready;
  logic               keep_control;
  logic signed [31:0] camera_x;
  logic signed [31:0] camera_y;
  logic signed [31:0] camera_z;
  logic signed [15:0] camera_heading;
  logic signed [15:0] camera_pitch;
  logic signed [15:0] camera_roll;

  modport source (output valid, keep_control, camera_x, camera_y, camera_z,
                  camera_heading, camera_pitch, camera_roll, input ready);
  modport sink (input valid, keep_control, camera_x, camera_y, camera_z,
                camera_heading, camera_pitch, camera_roll, output ready);
endinterface

// ----- design/body_offset_camera_pose_core.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// body_offset_camera_pose_core: camera pose from vehicle pose and attitude
// Places a camera at a rotated station offset and picks its view angles.
// ---------------------------------------------------------------------------
// Usage:
//   pose  - input channel, one vehicle pose item per valid/ready handshake.
//   cam   - output channel, one camera pose item per input item, in order.
//   wr_*  - register write port; write only while no item is in flight.
// Throughput: one item per cycle while the receiver takes results; the
// 21-stage pipeline (angle reduction, Horner series steps split in
// multiply and divide stages, rotation products, offset sum, output
// register) moves as one.
// When the receiver stalls with a result waiting, the whole pipeline holds
// and pose.ready drops; bubbles do not collapse. Reset empties the pipeline
// and loads the register defaults; there is no clearing pass.
// ---------------------------------------------------------------------------
module body_offset_camera_pose_core (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           wr_en,
  input  logic [bop_pkg::CFG_IDX_W-1:0]  wr_index,
  input  logic [bop_pkg::CFG_DATA_W-1:0] wr_data,
  bop_in_if.sink                         pose,
  bop_out_if.source                      cam
);
  import bop_pkg::*;

  localparam int DEPTH = 21;
  localparam int HS    = 3;   // first Horner stage

  logic               gimbal_mode;
  logic signed [15:0] fpv_fwd, fpv_up, gim_fwd, gim_up;

  always_ff @(posedge clk) begin
    if (rst) begin
      gimbal_mode <= 1'b0;
      fpv_fwd     <= 16'sd2867;
      fpv_up      <= 16'sd410;
      gim_fwd     <= 16'sd1638;
      gim_up      <= -16'sd2048;
    end else if (wr_en) begin
      case (cfg_reg_t'(wr_index))
        REG_GIMBAL_MODE: gimbal_mode <= wr_data[0];
        REG_FPV_FWD:     fpv_fwd     <= wr_data;
        REG_FPV_UP:      fpv_up      <= wr_data;
        REG_GIM_FWD:     gim_fwd     <= wr_data;
        REG_GIM_UP:      gim_up      <= wr_data;
        default: ;
      endcase
    end
  end

  logic [DEPTH-1:0] vld;
  logic             en;

  assign en         = !vld[DEPTH-1] || cam.ready;
  assign pose.ready = en;
  assign cam.valid  = vld[DEPTH-1];

  always_ff @(posedge clk) begin
    if (rst) vld <= '0;
    else if (en) vld <= {vld[DEPTH-2:0], pose.valid};
  end

  // Angle reduction into quadrant and remainder
  logic signed [15:0] ang [3];
  logic signed [16:0] a_m [3];
  logic [1:0]         a_q [3];
  logic [12:0]        a_r [3];

  assign ang[0] = pose.vehicle_heading;
  assign ang[1] = pose.vehicle_pitch;
  assign ang[2] = pose.vehicle_roll;

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      a_m[l] = 17'(ang[l]);
      if (a_m[l] < 0) a_m[l] = a_m[l] + FULL_TURN;
      if (a_m[l] < 0) a_m[l] = a_m[l] + FULL_TURN;
      if (a_m[l] >= FULL_TURN) a_m[l] = a_m[l] - FULL_TURN;
      if (a_m[l] >= 3 * QUARTER_TURN) begin
        a_q[l] = 2'd3;
        a_r[l] = 13'(a_m[l] - 3 * QUARTER_TURN);
      end else if (a_m[l] >= 2 * QUARTER_TURN) begin
        a_q[l] = 2'd2;
        a_r[l] = 13'(a_m[l] - 2 * QUARTER_TURN);
      end else if (a_m[l] >= QUARTER_TURN) begin
        a_q[l] = 2'd1;
        a_r[l] = 13'(a_m[l] - QUARTER_TURN);
      end else begin
        a_q[l] = 2'd0;
        a_r[l] = 13'(a_m[l]);
      end
    end
  end

  lane_t  ln [16][3];
  carry_t cr [20];

  logic signed [36:0] pan_prod, tilt_prod;

  // Gimbal angles from the registered pan/tilt products
  logic signed [36:0] pan_w, tilt_w;
  logic signed [17:0] gh_sum, gp_sum;
  logic signed [15:0] gh_sat, gp_sat;

  always_comb begin
    pan_w  = (pan_prod + 37'sd524288) >>> 20;
    tilt_w = (tilt_prod + 37'sd524288) >>> 20;
    gh_sum = 18'(cr[0].hd) + pan_w[17:0];
    gp_sum = tilt_w[17:0];
    if (gh_sum > 18'sd32767)       gh_sat = 16'sh7fff;
    else if (gh_sum < -18'sd32768) gh_sat = 16'sh8000;
    else                           gh_sat = gh_sum[15:0];
    if (gp_sum > 18'sd32767)       gp_sat = 16'sh7fff;
    else if (gp_sum < -18'sd32768) gp_sat = 16'sh8000;
    else                           gp_sat = gp_sum[15:0];
  end

  // Divide stages of the Horner steps
  logic [64:0] hs_prod [NSTEP][3];
  logic [64:0] hc_prod [NSTEP][3];
  logic [31:0] hs_q    [NSTEP][3];
  logic [31:0] hc_q    [NSTEP][3];
  logic [30:0] hs_t    [NSTEP][3];
  logic [30:0] hc_t    [NSTEP][3];

  always_comb begin
    for (int i = 0; i < NSTEP; i++) begin
      for (int l = 0; l < 3; l++) begin
        hs_prod[i][l] = 65'(ln[HS+2*i][l].ps) * 65'(SIN_M[i]);
        hc_prod[i][l] = 65'(ln[HS+2*i][l].pc) * 65'(COS_M[i]);
        hs_q[i][l]    = 32'(hs_prod[i][l] >> SIN_K[i]);
        hc_q[i][l]    = 32'(hc_prod[i][l] >> COS_K[i]);
        hs_t[i][l]    = Q_ONE - hs_q[i][l][30:0];
        // clamp the cosine term at zero
        hc_t[i][l]    = (hc_q[i][l] > 32'(Q_ONE)) ? '0 : Q_ONE - hc_q[i][l][30:0];
      end
    end
  end

  logic signed [31:0] sn [3];
  logic signed [31:0] cs [3];
  logic signed [31:0] sv [3];
  logic signed [31:0] cv [3];

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      sv[l] = signed'({1'b0, ln[15][l].ts});
      cv[l] = signed'({1'b0, ln[15][l].tc});
    end
  end

  // Rotation stages
  logic signed [31:0] fx, fy, fz, u0x, u0z, uy;
  logic signed [31:0] r_sh, r_ch, r_sr, r_cr;
  logic signed [31:0] fx2, fy2, fz2, uy2;
  logic signed [33:0] ux, uz;
  logic signed [33:0] ox, oy, oz;
  logic signed [15:0] fo, uo;

  assign fo = gimbal_mode ? gim_fwd : fpv_fwd;
  assign uo = gimbal_mode ? gim_up : fpv_up;

  function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
    if (v > 34'sd2147483647)       return 32'sh7fff_ffff;
    else if (v < -34'sd2147483648) return 32'sh8000_0000;
    else                           return v[31:0];
  endfunction

  always_ff @(posedge clk) begin
    if (en) begin
      // stage 0: reduce angles, gimbal products
      for (int l = 0; l < 3; l++) begin
        ln[0][l]   <= '0;
        ln[0][l].q <= a_q[l];
        ln[0][l].x <= 31'(a_r[l]);
      end
      pan_prod  <= 37'(pose.gimbal_pan) * 37'(RAD_TO_UNIT);
      tilt_prod <= 37'(pose.gimbal_tilt) * 37'(RAD_TO_UNIT);
      cr[0] <= '{lose: pose.losing_control, vx: pose.vehicle_x, vy: pose.vehicle_y,
                 vz: pose.vehicle_z, hd: pose.vehicle_heading, pt: pose.vehicle_pitch,
                 rl: pose.vehicle_roll, gh: 16'sd0, gp: 16'sd0};
      // stage 1: remainder to Q30 radians
      for (int l = 0; l < 3; l++) begin
        ln[1][l]   <= ln[0][l];
        ln[1][l].x <= 31'(32'(ln[0][l].x[12:0]) * 32'(RAD_PER_UNIT));
      end
      cr[1]    <= cr[0];
      cr[1].gh <= gh_sat;
      cr[1].gp <= gp_sat;
      for (int j = 2; j < 20; j++) cr[j] <= cr[j-1];
      // stage 2: square
      for (int l = 0; l < 3; l++) begin
        ln[2][l]    <= ln[1][l];
        ln[2][l].x2 <= 32'((64'(ln[1][l].x) * 64'(ln[1][l].x)) >> 30);
        ln[2][l].ts <= Q_ONE;
        ln[2][l].tc <= Q_ONE;
      end
      // Horner steps: multiply stage, then divide stage
      for (int i = 0; i < NSTEP; i++) begin
        for (int l = 0; l < 3; l++) begin
          ln[HS+2*i][l]    <= ln[HS-1+2*i][l];
          ln[HS+2*i][l].ps <= 32'((64'(ln[HS-1+2*i][l].x2) * 64'(ln[HS-1+2*i][l].ts)) >> 30);
          ln[HS+2*i][l].pc <= 32'((64'(ln[HS-1+2*i][l].x2) * 64'(ln[HS-1+2*i][l].tc)) >> 30);
          ln[HS+1+2*i][l]    <= ln[HS+2*i][l];
          ln[HS+1+2*i][l].ts <= hs_t[i][l];
          ln[HS+1+2*i][l].tc <= hc_t[i][l];
        end
      end
      // stage 15: sine = x * series
      for (int l = 0; l < 3; l++) begin
        ln[15][l]    <= ln[14][l];
        ln[15][l].ts <= 31'((62'(ln[14][l].x) * 62'(ln[14][l].ts)) >> 30);
      end
      // stage 16: quadrant symmetry
      for (int l = 0; l < 3; l++) begin
        case (ln[15][l].q)
          2'd0:    begin sn[l] <= sv[l];  cs[l] <= cv[l];  end
          2'd1:    begin sn[l] <= cv[l];  cs[l] <= -sv[l]; end
          2'd2:    begin sn[l] <= -sv[l]; cs[l] <= -cv[l]; end
          default: begin sn[l] <= -cv[l]; cs[l] <= sv[l];  end
        endcase
      end
      // stage 17: forward axis and unrolled up axis
      fx   <= 32'(rnd30(64'(sn[0]) * 64'(cs[1])));
      fy   <= sn[1];
      fz   <= -(32'(rnd30(64'(cs[0]) * 64'(cs[1]))));
      u0x  <= -(32'(rnd30(64'(sn[0]) * 64'(sn[1]))));
      u0z  <= 32'(rnd30(64'(cs[0]) * 64'(sn[1])));
      uy   <= 32'(rnd30(64'(cs[1]) * 64'(cs[2])));
      r_sh <= sn[0];
      r_ch <= cs[0];
      r_sr <= sn[2];
      r_cr <= cs[2];
      // stage 18: apply roll
      ux  <= rnd30(64'(u0x) * 64'(r_cr) + 64'(r_ch) * 64'(r_sr));
      uz  <= rnd30(64'(u0z) * 64'(r_cr) + 64'(r_sh) * 64'(r_sr));
      fx2 <= fx;
      fy2 <= fy;
      fz2 <= fz;
      uy2 <= uy;
      // stage 19: station offset
      ox <= rnd30(64'(fo) * 64'(fx2) + 64'(uo) * 64'(ux));
      oy <= rnd30(64'(fo) * 64'(fy2) + 64'(uo) * 64'(34'(uy2)));
      oz <= rnd30(64'(fo) * 64'(fz2) + 64'(uo) * 64'(uz));
      // stage 20: output register; zero pose on a losing notice
      if (cr[19].lose) begin
        cam.keep_control   <= 1'b0;
        cam.camera_x       <= '0;
        cam.camera_y       <= '0;
        cam.camera_z       <= '0;
        cam.camera_heading <= '0;
        cam.camera_pitch   <= '0;
        cam.camera_roll    <= '0;
      end else begin
        cam.keep_control   <= 1'b1;
        cam.camera_x       <= sat32(34'(cr[19].vx) + ox);
        cam.camera_y       <= sat32(34'(cr[19].vy) + oy);
        cam.camera_z       <= sat32(34'(cr[19].vz) + oz);
        cam.camera_heading <= gimbal_mode ? cr[19].gh : cr[19].hd;
        cam.camera_pitch   <= gimbal_mode ? cr[19].gp : cr[19].pt;
        cam.camera_roll    <= gimbal_mode ? 16'sd0 : cr[19].rl;
      end
    end
  end

endmodule

// ----- design/bop_checker.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bop_checker: port-level checks for the camera pose pipeline
// Watches the channels of the top level over time; bound to the top level.
// ---------------------------------------------------------------------------
module bop_checker (
  input logic               clk,
  input logic               rst,
  input logic               pose_ready,
  input logic               cam_valid,
  input logic               cam_ready,
  input logic               keep_control,
  input logic signed [31:0] camera_x,
  input logic signed [31:0] camera_y,
  input logic signed [31:0] camera_z,
  input logic signed [15:0] camera_heading,
  input logic signed [15:0] camera_pitch,
  input logic signed [15:0] camera_roll
);

  // held result stays offered
  a_hold: assert property (@(posedge clk) disable iff (rst)
    cam_valid && !cam_ready |=> cam_valid)
    else $error("result dropped while stalled");

  a_ready: assert property (@(posedge clk) disable iff (rst)
    pose_ready == (!cam_valid || cam_ready))
    else $error("input ready does not follow output stall");

  a_rst: assert property (@(posedge clk) rst |=> !cam_valid)
    else $error("result offered right after reset");

  a_lose: assert property (@(posedge clk) disable iff (rst)
    cam_valid && !keep_control |-> camera_x == 0 && camera_y == 0 && camera_z == 0 &&
      camera_heading == 0 && camera_pitch == 0 && camera_roll == 0)
    else $error("released control carries a nonzero pose");

endmodule

bind body_offset_camera_pose_core bop_checker u_bop_checker (
  .clk            (clk),
  .rst            (rst),
  .pose_ready     (pose.ready),
  .cam_valid      (cam.valid),
  .cam_ready      (cam.ready),
  .keep_control   (cam.keep_control),
  .camera_x       (cam.camera_x),
  .camera_y       (cam.camera_y),
  .camera_z       (cam.camera_z),
  .camera_heading (cam.camera_heading),
  .camera_pitch   (cam.camera_pitch),
  .camera_roll    (cam.camera_roll)
);
